[rtl/abrm_pkg.sv]
// Shared types, codes and widths of the audio buffer ring manager.
`default_nettype none

package abrm_pkg;

    // Default ring depth limit; the index width follows from it.
    localparam int MAX_BUFFERS_DEF = 1024;

    // Fixed field widths.
    localparam int CNT_W   = 11;
    localparam int BYTES_W = 17;
    localparam int ADDR_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 3;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 72;

    // Request kinds.
    localparam logic [FUNC_W-1:0] FUNC_APP   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DMA   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BUSY    = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_BUFFER_COUNT = 3'd0;
    localparam logic [CIDX_W-1:0] REG_BUFFER_BYTES = 3'd1;
    localparam logic [CIDX_W-1:0] REG_USER_BASE    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_DMA_BASE     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_SILENCE      = 3'd4;

    typedef struct packed {
        logic [CNT_W-1:0]   buffer_count;
        logic [BYTES_W-1:0] buffer_bytes;
        logic [ADDR_W-1:0]  user_base_address;
        logic [ADDR_W-1:0]  dma_base_address;
        logic [ADDR_W-1:0]  silence_address;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              filled_valid;
        logic              want_next;
    } t_item;

    typedef struct packed {
        logic              space_available;
        logic [ADDR_W-1:0] dma_address;
        logic [ADDR_W-1:0] next_address;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

[rtl/audio_buffer_ring_manager_top.sv]
// Top level of the audio buffer ring manager: ports, configuration and stages.
`default_nettype none

// Channel   Direction  Handshake                      Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata, tuser: one request
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata: one result
// cfg       in         i_cfg_we (no back-pressure)     i_cfg_index, i_cfg_data
//
// Every request produces exactly one result: it passes the input register, then
// the index update, the shared buffer address multiplier and adder, and goes
// into the result register.
// A new request is accepted every cycle while results are taken; the rate is set
// by the combinational index update and address multiply-add in the core.
// Reset is synchronous and active low; it clears all three ring indices, the
// stage valid flags and restores the register defaults (two buffers of 4096
// bytes, all addresses zero). There is no clearing pass.
// A stall on the result side backs up through the result register and the
// input register; nothing is lost or repeated while tready is low.

module audio_buffer_ring_manager_top #(
    parameter int MAX_BUFFERS = abrm_pkg::MAX_BUFFERS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,

    input  wire                           i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // Fields from bit 0: filled_valid, want_next, zero fill.
    input  wire [abrm_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // Fields from bit 0: func (2 bits), zero fill.
    input  wire [abrm_pkg::S_TUSER_W-1:0] i_s_axis_tuser,

    output logic                          o_m_axis_tvalid,
    input  wire                           i_m_axis_tready,
    // Fields from bit 0: status (2), next_address (32), dma_address (32),
    // space_available (1), zero fill.
    output logic [abrm_pkg::M_TDATA_W-1:0] o_m_axis_tdata,

    input  wire                           i_cfg_we,
    input  wire [abrm_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire [abrm_pkg::ADDR_W-1:0]    i_cfg_data
);

    localparam int RES_W = $bits(abrm_pkg::t_result);

    abrm_pkg::t_cfg    cfg;
    abrm_pkg::t_item   in_item, stage_item;
    abrm_pkg::t_result res;
    logic              stage_valid;
    logic              core_ready;

    // Unpack the request from the stream fields.
    assign in_item.func         = i_s_axis_tuser[abrm_pkg::FUNC_W-1:0];
    assign in_item.filled_valid = i_s_axis_tdata[0];
    assign in_item.want_next    = i_s_axis_tdata[1];

    abrm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    abrm_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_item       (in_item),
        .i_core_ready (core_ready),
        .o_valid      (stage_valid),
        .o_item       (stage_item)
    );

    abrm_core #(
        .MAX_BUFFERS (MAX_BUFFERS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_ready     (core_ready),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    // The result struct is declared status-first from the low end.
    assign o_m_axis_tdata = {{(abrm_pkg::M_TDATA_W - RES_W){1'b0}}, res};

endmodule

`default_nettype wire

[rtl/abrm_cfg.sv]
// Configuration register file of the audio buffer ring manager.
`default_nettype none

module abrm_cfg (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [abrm_pkg::CIDX_W-1:0]  i_cfg_index,
    input  wire [abrm_pkg::ADDR_W-1:0]  i_cfg_data,
    output abrm_pkg::t_cfg              o_cfg
);

    abrm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_count      <= abrm_pkg::CNT_W'(2);
            r_cfg.buffer_bytes      <= abrm_pkg::BYTES_W'(4096);
            r_cfg.user_base_address <= '0;
            r_cfg.dma_base_address  <= '0;
            r_cfg.silence_address   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                abrm_pkg::REG_BUFFER_COUNT: begin
                    r_cfg.buffer_count <= i_cfg_data[abrm_pkg::CNT_W-1:0];
                end
                abrm_pkg::REG_BUFFER_BYTES: begin
                    r_cfg.buffer_bytes <= i_cfg_data[abrm_pkg::BYTES_W-1:0];
                end
                abrm_pkg::REG_USER_BASE: begin
                    r_cfg.user_base_address <= i_cfg_data;
                end
                abrm_pkg::REG_DMA_BASE: begin
                    r_cfg.dma_base_address <= i_cfg_data;
                end
                abrm_pkg::REG_SILENCE: begin
                    r_cfg.silence_address <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/abrm_in_stage.sv]
// Input register that holds one request until the core takes it.
`default_nettype none

module abrm_in_stage (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  abrm_pkg::t_item i_item,
    input  wire             i_core_ready,
    output logic            o_valid,
    output abrm_pkg::t_item o_item
);

    logic            r_valid;
    abrm_pkg::t_item r_item;
    logic            take;

    assign take    = r_valid && i_core_ready;
    assign o_ready = !r_valid || i_core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[rtl/abrm_core.sv]
// Ring indices, request decode, address forming and the result register.
`default_nettype none

module abrm_core #(
    parameter int MAX_BUFFERS = abrm_pkg::MAX_BUFFERS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  abrm_pkg::t_cfg    i_cfg,
    input  wire               i_valid,
    input  abrm_pkg::t_item   i_item,
    output logic              o_ready,
    output logic              o_res_valid,
    input  wire               i_res_ready,
    output abrm_pkg::t_result o_res
);

    localparam int IW = $clog2(MAX_BUFFERS);
    localparam int EW = (IW + 1 > abrm_pkg::CNT_W) ? IW + 1 : abrm_pkg::CNT_W;
    localparam int PW = IW + abrm_pkg::BYTES_W;

    logic [IW-1:0] r_handout, r_filled, r_play;
    logic [IW-1:0] n_handout, n_filled, n_play;
    logic [IW-1:0] h_step, f_step, p_step;

    logic              r_res_valid;
    abrm_pkg::t_result r_res, n_res;

    logic [EW-1:0] cnt_ext, eff;
    logic          single;
    logic          adv;

    logic [IW-1:0]                mul_idx;
    logic [abrm_pkg::ADDR_W-1:0]  mul_base;
    logic [PW-1:0]                prod;
    logic [abrm_pkg::ADDR_W-1:0]  buf_addr;

    function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] i,
                                               input logic [EW-1:0] e);
        logic [IW:0] n;
        n = {1'b0, i} + (IW+1)'(1);
        if (EW'(n) >= e) begin
            return '0;
        end
        return n[IW-1:0];
    endfunction

    assign cnt_ext = EW'(i_cfg.buffer_count);
    assign eff     = (cnt_ext > EW'(MAX_BUFFERS)) ? EW'(MAX_BUFFERS) : cnt_ext;
    assign single  = (i_cfg.buffer_count == abrm_pkg::CNT_W'(1));

    assign o_ready = !r_res_valid || i_res_ready;
    assign adv     = i_valid && o_ready;

    assign h_step = step_idx(r_handout, eff);
    assign f_step = step_idx(r_filled, eff);
    assign p_step = step_idx(r_play, eff);

    // One multiplier serves both sides: completions use the play index.
    assign mul_idx  = (i_item.func == abrm_pkg::FUNC_DMA) ? r_play : r_handout;
    assign mul_base = (i_item.func == abrm_pkg::FUNC_DMA) ? i_cfg.dma_base_address
                                                          : i_cfg.user_base_address;
    assign prod     = PW'(mul_idx) * PW'(i_cfg.buffer_bytes);
    assign buf_addr = mul_base + abrm_pkg::ADDR_W'(prod);

    always_comb begin
        n_handout = r_handout;
        n_filled  = r_filled;
        n_play    = r_play;
        n_res     = '0;
        n_res.status = abrm_pkg::STAT_OK;
        case (i_item.func)
            abrm_pkg::FUNC_APP: begin
                if (i_item.filled_valid && !i_item.want_next) begin
                    n_res.status = abrm_pkg::STAT_INVALID;
                end else begin
                    if (i_item.filled_valid) begin
                        n_filled = f_step;
                    end
                    if (i_item.want_next) begin
                        if (single) begin
                            n_res.next_address = i_cfg.user_base_address;
                        end else if (h_step == r_play) begin
                            n_res.status = abrm_pkg::STAT_BUSY;
                        end else begin
                            n_res.next_address = buf_addr;
                            n_handout          = h_step;
                        end
                    end
                end
            end
            abrm_pkg::FUNC_DMA: begin
                if (single) begin
                    n_res.dma_address = i_cfg.dma_base_address;
                end else if (r_filled != r_play) begin
                    n_res.dma_address = buf_addr;
                    n_play            = p_step;
                end else begin
                    n_res.dma_address = i_cfg.silence_address;
                end
            end
            abrm_pkg::FUNC_CLEAR: begin
                n_handout = '0;
                n_filled  = '0;
                n_play    = '0;
            end
            default: begin
                n_res.status = abrm_pkg::STAT_INVALID;
            end
        endcase
        n_res.space_available = (step_idx(n_handout, eff) != n_play);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handout   <= '0;
            r_filled    <= '0;
            r_play      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_handout   <= n_handout;
                r_filled    <= n_filled;
                r_play      <= n_play;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && i_item.func == abrm_pkg::FUNC_CLEAR)
        |=> (r_handout == '0 && r_filled == '0 && r_play == '0))
        else $error("clear request left an index nonzero");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_handout) && $stable(r_filled) && $stable(r_play)))
        else $error("ring index moved without a request");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> $past(adv))
        else $error("result appeared without a request");

    a_dma_keeps_handout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && i_item.func == abrm_pkg::FUNC_DMA) |=> $stable(r_handout))
        else $error("completion moved the hand-out index");

    a_busy_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.status == abrm_pkg::STAT_BUSY)
        |-> (r_res.next_address == '0 && r_res.dma_address == '0))
        else $error("busy result carries an address");

endmodule

`default_nettype wire

[tb/abrm_checker.sv]
// Checker for the audio buffer ring manager: mirrors the ring state and compares every result.
module abrm_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    input  wire                                i_s_tready,
    input  wire [abrm_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  wire [abrm_pkg::S_TUSER_W-1:0]      i_s_tuser,
    input  wire                                i_m_tvalid,
    input  wire                                i_m_tready,
    input  wire [abrm_pkg::M_TDATA_W-1:0]      i_m_tdata,
    input  wire                                i_cfg_we,
    input  wire [abrm_pkg::CIDX_W-1:0]         i_cfg_index,
    input  wire [abrm_pkg::ADDR_W-1:0]         i_cfg_data,
    input  wire                                i_end_of_test,
    output int                                 o_fail_count,
    output int                                 o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(abrm_pkg::MAX_BUFFERS_DEF);

    // Mirror of the configuration registers.
    logic [abrm_pkg::CNT_W-1:0]   ring_count;
    logic [abrm_pkg::BYTES_W-1:0] ring_bytes;
    logic [abrm_pkg::ADDR_W-1:0]  user_base;
    logic [abrm_pkg::ADDR_W-1:0]  dma_base;
    logic [abrm_pkg::ADDR_W-1:0]  silence_base;

    // Mirror of the three ring indices.
    logic [IDX_W-1:0] handout_idx;
    logic [IDX_W-1:0] filled_idx;
    logic [IDX_W-1:0] play_idx;

    abrm_pkg::t_result pending_results[$];
    int                mismatch_count = 0;
    bit                end_checked = 1'b0;

    // One step around the ring; counts above the depth limit are clipped to it.
    function automatic logic [IDX_W-1:0] ring_step(input logic [IDX_W-1:0] idx);
        logic [abrm_pkg::CNT_W-1:0] lim;
        logic [abrm_pkg::CNT_W-1:0] nxt;
        lim = (ring_count > abrm_pkg::CNT_W'(abrm_pkg::MAX_BUFFERS_DEF)) ?
              abrm_pkg::CNT_W'(abrm_pkg::MAX_BUFFERS_DEF) : ring_count;
        nxt = abrm_pkg::CNT_W'(idx) + 1'b1;
        if (nxt >= lim)
            nxt = '0;
        return nxt[IDX_W-1:0];
    endfunction

    function automatic logic [abrm_pkg::ADDR_W-1:0] buf_address(
        input logic [abrm_pkg::ADDR_W-1:0] base, input logic [IDX_W-1:0] idx);
        return base + 32'(idx) * 32'(ring_bytes);
    endfunction

    // Applies one request to the mirrored ring and returns the result it must give.
    task automatic ring_predict(input logic [abrm_pkg::FUNC_W-1:0] func, input logic fill,
                                input logic want, output abrm_pkg::t_result res);
        logic single;
        single = (ring_count == abrm_pkg::CNT_W'(1));
        res = '0;
        res.status = abrm_pkg::STAT_OK;
        case (func)
            abrm_pkg::FUNC_APP: begin
                if (fill && !want) begin
                    res.status = abrm_pkg::STAT_INVALID;
                end else begin
                    // The filled mark is taken even when the hand-out turns out busy.
                    if (fill)
                        filled_idx = ring_step(filled_idx);
                    if (want) begin
                        if (single) begin
                            res.next_address = user_base;
                        end else if (ring_step(handout_idx) == play_idx) begin
                            res.status = abrm_pkg::STAT_BUSY;
                        end else begin
                            res.next_address = buf_address(user_base, handout_idx);
                            handout_idx = ring_step(handout_idx);
                        end
                    end
                end
            end
            abrm_pkg::FUNC_DMA: begin
                if (single) begin
                    res.dma_address = dma_base;
                end else if (filled_idx != play_idx) begin
                    res.dma_address = buf_address(dma_base, play_idx);
                    play_idx = ring_step(play_idx);
                end else begin
                    res.dma_address = silence_base;
                end
            end
            abrm_pkg::FUNC_CLEAR: begin
                handout_idx = '0;
                filled_idx  = '0;
                play_idx    = '0;
            end
            default: res.status = abrm_pkg::STAT_INVALID;
        endcase
        res.space_available = (ring_step(handout_idx) != play_idx);
    endtask

    always @(posedge i_clk) begin
        abrm_pkg::t_result got;
        abrm_pkg::t_result want;
        abrm_pkg::t_result pred;
        if (!i_rst_n) begin
            ring_count   = abrm_pkg::CNT_W'(2);
            ring_bytes   = abrm_pkg::BYTES_W'(4096);
            user_base    = '0;
            dma_base     = '0;
            silence_base = '0;
            handout_idx  = '0;
            filled_idx   = '0;
            play_idx     = '0;
            pending_results.delete();
        end else begin
            // Results leave before this edge's request enters, so compare first.
            if (i_m_tvalid && i_m_tready) begin
                got = abrm_pkg::t_result'(i_m_tdata[$bits(abrm_pkg::t_result)-1:0]);
                o_results_seen <= o_results_seen + 1;
                if (pending_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.next_address !== want.next_address) begin
                        $error("next_address mismatch: expected %h, actual %h",
                               want.next_address, got.next_address);
                        mismatch_count++;
                    end
                    if (got.dma_address !== want.dma_address) begin
                        $error("dma_address mismatch: expected %h, actual %h",
                               want.dma_address, got.dma_address);
                        mismatch_count++;
                    end
                    if (got.space_available !== want.space_available) begin
                        $error("space_available mismatch: expected %0d, actual %0d",
                               want.space_available, got.space_available);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                ring_predict(i_s_tuser[abrm_pkg::FUNC_W-1:0], i_s_tdata[0], i_s_tdata[1],
                             pred);
                pending_results.push_back(pred);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    abrm_pkg::REG_BUFFER_COUNT: ring_count   = i_cfg_data[abrm_pkg::CNT_W-1:0];
                    abrm_pkg::REG_BUFFER_BYTES: ring_bytes   = i_cfg_data[abrm_pkg::BYTES_W-1:0];
                    abrm_pkg::REG_USER_BASE:    user_base    = i_cfg_data;
                    abrm_pkg::REG_DMA_BASE:     dma_base     = i_cfg_data;
                    abrm_pkg::REG_SILENCE:      silence_base = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_end_of_test && !end_checked) begin
                end_checked = 1'b1;
                if (pending_results.size() != 0) begin
                    $error("%0d results never arrived", pending_results.size());
                    mismatch_count++;
                end
            end
        end
        o_fail_count <= mismatch_count;
    end

endmodule

[tb/tb.sv]
// Testbench top for the audio buffer ring manager: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The one func code that the block does not define.
    localparam logic [abrm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    // A register index that maps to no register; a write there must change nothing.
    localparam logic [abrm_pkg::CIDX_W-1:0] REG_UNUSED  = 3'd7;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PRESSURE_PHASE  = 4;
    localparam int LONG_HOLD       = 300;
    localparam int TAIL_CYCLES     = 10;
    // Longest legal quiet stretch is the long hold plus the random stalls and gaps.
    localparam int WATCHDOG_LIMIT  = 5000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [abrm_pkg::S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [abrm_pkg::S_TUSER_W-1:0] i_s_axis_tuser = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [abrm_pkg::M_TDATA_W-1:0] o_m_axis_tdata;
    logic                           i_cfg_we = 1'b0;
    logic [abrm_pkg::CIDX_W-1:0]    i_cfg_index = '0;
    logic [abrm_pkg::ADDR_W-1:0]    i_cfg_data = '0;
    logic                           end_of_test = 1'b0;

    int  fail_count;
    int  results_seen;
    int  requests_sent = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_trigger = 1'b0;
    int  quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    audio_buffer_ring_manager_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    abrm_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_axis_tvalid),
        .i_s_tready     (o_s_axis_tready),
        .i_s_tdata      (i_s_axis_tdata),
        .i_s_tuser      (i_s_axis_tuser),
        .i_m_tvalid     (o_m_axis_tvalid),
        .i_m_tready     (i_m_axis_tready),
        .i_m_tdata      (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_end_of_test  (end_of_test),
        .o_fail_count   (fail_count),
        .o_results_seen (results_seen)
    );

    // Result side. Normally it stalls at the phase's rate; when the stimulus flips
    // hold_trigger it holds tready low for a long stretch, counted here, so that the
    // block's registers fill and it has to stall its input.
    int  hold_left = 0;
    bit  hold_seen = 1'b0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_trigger != hold_seen) begin
            hold_seen       <= hold_trigger;
            hold_left       <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: any cycle that moves a request on either channel resets the count.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("audio_buffer_ring_manager_top regression: fail");
            $finish;
        end
    end

    // Offers one request after a random gap and returns at the edge that accepts it.
    // tvalid stays high from one request to the next when there is no gap.
    task automatic offer_request(input logic [abrm_pkg::FUNC_W-1:0] func, input logic fill,
                                 input logic want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= abrm_pkg::S_TDATA_W'({want, fill});
        i_s_axis_tuser  <= abrm_pkg::S_TUSER_W'(func);
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        requests_sent++;
    endtask

    // Mostly producer and consumer traffic: fill-and-fetch requests paired with DMA
    // completions, with some plain fetches, clears and malformed requests mixed in.
    task automatic offer_random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b1);
        else if (pick < 55)
            offer_request(abrm_pkg::FUNC_APP, 1'b0, 1'b1);
        else if (pick < 60)
            offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b0);
        else if (pick < 62)
            offer_request(abrm_pkg::FUNC_APP, 1'b0, 1'b0);
        else if (pick < 92)
            offer_request(abrm_pkg::FUNC_DMA, 1'b0, 1'b0);
        else if (pick < 96)
            offer_request(abrm_pkg::FUNC_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
            offer_request(FUNC_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Stops offering and waits until every accepted request has produced its result.
    task automatic drain_ring();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_seen < requests_sent)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [abrm_pkg::CIDX_W-1:0] idx,
                             input logic [abrm_pkg::ADDR_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Reprograms all five registers while the block is idle. The count and size writes
    // carry random junk above the register width, which the block must drop.
    task automatic program_ring(input logic [abrm_pkg::CNT_W-1:0] count,
                                input logic [abrm_pkg::BYTES_W-1:0] bytes,
                                input logic [abrm_pkg::ADDR_W-1:0] ubase,
                                input logic [abrm_pkg::ADDR_W-1:0] dbase,
                                input logic [abrm_pkg::ADDR_W-1:0] silence);
        drain_ring();
        cfg_write(abrm_pkg::REG_BUFFER_COUNT, (32'($urandom) & ~32'h7FF) | 32'(count));
        cfg_write(abrm_pkg::REG_BUFFER_BYTES, (32'($urandom) & ~32'h1FFFF) | 32'(bytes));
        cfg_write(abrm_pkg::REG_USER_BASE, ubase);
        cfg_write(abrm_pkg::REG_DMA_BASE, dbase);
        cfg_write(abrm_pkg::REG_SILENCE, silence);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [abrm_pkg::CNT_W-1:0]   count;
        logic [abrm_pkg::BYTES_W-1:0] bytes;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset settings (two buffers of 4096 bytes): the unused code,
        // a filled mark without a fetch, an empty request, a completion with nothing
        // filled, then the ring running full with a filled mark taken while busy.
        offer_request(FUNC_UNUSED, 1'b1, 1'b1);
        offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b0);
        offer_request(abrm_pkg::FUNC_APP, 1'b0, 1'b0);
        offer_request(abrm_pkg::FUNC_DMA, 1'b0, 1'b0);
        offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b1);
        offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b1);
        offer_request(abrm_pkg::FUNC_DMA, 1'b1, 1'b1);
        offer_request(abrm_pkg::FUNC_CLEAR, 1'b0, 1'b0);

        // Single buffer with the largest size and addresses at the top of the space.
        program_ring(11'd1, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'h5A5A_0000);
        @(posedge i_clk);
        cfg_write(REG_UNUSED, 32'($urandom));
        i_cfg_we <= 1'b0;
        offer_request(abrm_pkg::FUNC_APP, 1'b0, 1'b1);
        offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b1);
        offer_request(abrm_pkg::FUNC_DMA, 1'b0, 1'b0);

        // Count zero: every step lands on index zero.
        program_ring(11'd0, 17'd4096, 32'h1000_0000, 32'h8000_0000, 32'hCAFE_0000);
        offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b1);
        offer_request(abrm_pkg::FUNC_DMA, 1'b0, 1'b0);

        // Largest count field, clipped to the depth limit, with address overflow.
        program_ring(11'h7FF, 17'd65536, 32'hFFFF_0000, 32'hFFFF_8000, 32'h0000_0001);
        offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b1);
        offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b1);
        offer_request(abrm_pkg::FUNC_DMA, 1'b0, 1'b0);

        // Indices left beyond a count that shrank: they wrap on the next step.
        program_ring(11'd8, 17'd256, 32'h0000_4000, 32'h2000_0000, 32'h0000_0000);
        repeat (5) offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b1);
        program_ring(11'd3, 17'd256, 32'h0000_4000, 32'h2000_0000, 32'h0000_0000);
        offer_request(abrm_pkg::FUNC_APP, 1'b1, 1'b1);
        offer_request(abrm_pkg::FUNC_DMA, 1'b0, 1'b0);

        // Random part: each phase takes fresh settings and one of four idling patterns.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                program_ring(11'd1024, 17'd65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end else if (ph == 1) begin
                program_ring(11'd2, 17'd1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
            end else begin
                case ($urandom_range(9))
                    0:       count = abrm_pkg::CNT_W'($urandom_range(2047));
                    1:       count = abrm_pkg::CNT_W'(1);
                    2:       count = abrm_pkg::CNT_W'(0);
                    default: count = abrm_pkg::CNT_W'($urandom_range(2, 12));
                endcase
                bytes = abrm_pkg::BYTES_W'($urandom);
                program_ring(count, bytes, 32'($urandom), 32'($urandom), 32'($urandom));
            end

            case (ph % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 69; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 69; end
                default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            // In the pressure phase the sender never pauses while the result side
            // holds off, so the block backs up all the way to its input.
            if (ph == PRESSURE_PHASE) begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
                hold_trigger <= ~hold_trigger;
            end

            repeat (ITEMS_PER_PHASE) offer_random_request();
        end

        drain_ring();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge i_clk);

        if (fail_count == 0)
            $display("audio_buffer_ring_manager_top regression: pass");
        else
            $display("audio_buffer_ring_manager_top regression: fail");
        $finish;
    end

endmodule
